FILE: src/lpd_pkg.sv
package lpd_pkg;

	localparam int unsigned HeaderBytes = 4;
	localparam int unsigned ByteBits = 8;
	localparam int unsigned LenBits = 2 * ByteBits;

	typedef enum logic [2:0] {
		PH_ID      = 3'd0,
		PH_COMP    = 3'd1,
		PH_LEN_LO  = 3'd2,
		PH_LEN_HI  = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	// one result item as it leaves the parser
	typedef struct packed {
		logic                valid;
		logic [ByteBits-1:0] packet_id;
		logic                compressed;
		logic [ByteBits-1:0] payload_byte;
		logic                last;
		logic                empty_packet;
		logic                length_error;
	} result_t;

endpackage

FILE: src/lpd_parser.sv
module lpd_parser import lpd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [ByteBits-1:0] rx_byte,
	output result_t             res
);

	phase_t              phase_q, phase_d;
	logic [ByteBits-1:0] id_q, id_d;
	logic                comp_q, comp_d;
	logic [ByteBits-1:0] len_lo_q, len_lo_d;
	logic [LenBits-1:0]  remain_q, remain_d;

	logic [LenBits-1:0]  total;
	logic [LenBits-1:0]  remain_dec;

	assign total      = {rx_byte, len_lo_q};
	assign remain_dec = (remain_q != '0) ? remain_q - LenBits'(1) : '0;

	// hold parser state; advance only on a step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_ID;
			id_q     <= '0;
			comp_q   <= 1'b0;
			len_lo_q <= '0;
			remain_q <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			id_q     <= id_d;
			comp_q   <= comp_d;
			len_lo_q <= len_lo_d;
			remain_q <= remain_d;
		end
	end

	// next state and result for one byte
	always_comb begin
		phase_d          = phase_q;
		id_d             = id_q;
		comp_d           = comp_q;
		len_lo_d         = len_lo_q;
		remain_d         = remain_q;
		res              = '0;
		res.packet_id    = id_q;
		res.compressed   = comp_q;
		unique case (phase_q)
			PH_COMP: begin
				comp_d  = (rx_byte != '0);
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				len_lo_d = rx_byte;
				phase_d  = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				if (total < LenBits'(HeaderBytes)) begin
					res.valid        = 1'b1;
					res.last         = 1'b1;
					res.length_error = 1'b1;
					phase_d          = PH_ID;
				end else if (total == LenBits'(HeaderBytes)) begin
					res.valid        = 1'b1;
					res.last         = 1'b1;
					res.empty_packet = 1'b1;
					phase_d          = PH_ID;
				end else begin
					remain_d = total - LenBits'(HeaderBytes);
					phase_d  = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				remain_d         = remain_dec;
				res.valid        = 1'b1;
				res.payload_byte = rx_byte;
				if (remain_dec == '0) begin
					res.last = 1'b1;
					phase_d  = PH_ID;
				end
			end
			default: begin
				id_d    = rx_byte;
				phase_d = PH_COMP;
			end
		endcase
	end

endmodule

FILE: src/length_prefixed_packet_deframer_unit.sv
// Channel  Dir  Fields (low bit up)                           Last
// s_*      in   tdata: rx_byte[7:0]                           -
// m_*      out  tdata: packet_id[7:0], payload_byte[15:8]     tlast = last
//               tuser: compressed, empty_packet, length_error
//
// One byte per cycle sustained while the output is not stalled. A byte is
// registered on input, parsed by the header/payload state logic once the output
// register is free, and its result, if any, lands in the output register.
// Reset clears the parser to expect an id byte and empties both registers.
// A stalled output holds its item; the input stage keeps moving whenever the
// output register is free or being drained in the same cycle.
module length_prefixed_packet_deframer_unit import lpd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // packet_id, payload_byte
	output logic        m_tlast,   // last
	output logic [2:0]  m_tuser    // compressed, empty_packet, length_error
);

	logic                valid_s1;
	logic [ByteBits-1:0] byte_s1;
	logic                out_free;
	logic                advance;
	result_t             res;
	result_t             res_load;
	result_t             out_q;

	assign out_free = !out_q.valid || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// capture input item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	lpd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.res     (res)
	);

	// qualify the parser result with a real step
	always_comb begin
		res_load       = res;
		res_load.valid = advance && res.valid;
	end

	// load result register; drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (out_free) begin
			out_q <= res_load;
		end
	end

	assign m_tvalid = out_q.valid;
	assign m_tdata  = {out_q.payload_byte, out_q.packet_id};
	assign m_tlast  = out_q.last;
	assign m_tuser  = {out_q.length_error, out_q.empty_packet, out_q.compressed};

endmodule

FILE: bench/length_prefixed_packet_deframer_unit_tb.sv
module length_prefixed_packet_deframer_unit_tb;
	import lpd_pkg::*;

	// Tracks the header parser and holds the results still due from the block
	class deframe_tracker;
		phase_t           phase;
		logic [7:0]       held_id;
		logic             held_comp;
		logic [7:0]       held_len_lo;
		logic [15:0]      remaining;
		result_t          due_results[$];
		int               mismatches;
		int               payload_count;
		int               empty_count;
		int               short_count;

		function new();
			phase = PH_ID;
			held_id = '0;
			held_comp = 1'b0;
			held_len_lo = '0;
			remaining = '0;
			mismatches = 0;
			payload_count = 0;
			empty_count = 0;
			short_count = 0;
		endfunction

		function void queue_result(logic [7:0] pay, logic last, logic empty, logic err);
			result_t r;
			r = '0;
			r.valid = 1'b1;
			r.packet_id = held_id;
			r.compressed = held_comp;
			r.payload_byte = pay;
			r.last = last;
			r.empty_packet = empty;
			r.length_error = err;
			due_results.push_back(r);
		endfunction

		// Advance the parser by one accepted byte
		function void take_byte(logic [7:0] b);
			logic [15:0] total;
			case (phase)
				PH_COMP: begin
					held_comp = (b != 8'd0);
					phase = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					held_len_lo = b;
					phase = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					total = {b, held_len_lo};
					if (total < HeaderBytes) begin
						queue_result(8'd0, 1'b1, 1'b0, 1'b1);
						short_count++;
						phase = PH_ID;
					end else if (total == HeaderBytes) begin
						queue_result(8'd0, 1'b1, 1'b1, 1'b0);
						empty_count++;
						phase = PH_ID;
					end else begin
						remaining = total - 16'(HeaderBytes);
						phase = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					if (remaining != 16'd0)
						remaining = remaining - 16'd1;
					queue_result(b, remaining == 16'd0, 1'b0, 1'b0);
					payload_count++;
					if (remaining == 16'd0)
						phase = PH_ID;
				end
				default: begin
					held_id = b;
					phase = PH_COMP;
				end
			endcase
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			mismatches++;
		endtask

		// Compare one item leaving the block with the oldest due result
		task match_item(logic [7:0] id, logic comp, logic [7:0] pay, logic last,
				logic empty, logic err);
			result_t e;
			if (due_results.size() == 0) begin
				report($sformatf("unexpected item id=%h byte=%h last=%b", id, pay, last));
				return;
			end
			e = due_results.pop_front();
			if (id !== e.packet_id)
				report($sformatf("packet_id %h, want %h", id, e.packet_id));
			if (comp !== e.compressed)
				report($sformatf("compressed %b, want %b", comp, e.compressed));
			if (pay !== e.payload_byte)
				report($sformatf("payload_byte %h, want %h", pay, e.payload_byte));
			if (last !== e.last)
				report($sformatf("last %b, want %b", last, e.last));
			if (empty !== e.empty_packet)
				report($sformatf("empty_packet %b, want %b", empty, e.empty_packet));
			if (err !== e.length_error)
				report($sformatf("length_error %b, want %b", err, e.length_error));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic [2:0]  m_tuser;

	deframe_tracker track;
	int send_idle_pct;
	int recv_stall_pct;
	int bytes_sent;
	int frames_sent;

	length_prefixed_packet_deframer_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Stall the output side at the rate of the current phase
	initial m_tready = 1'b0;
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Check every item taken from the output
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			track.match_item(m_tdata[7:0], m_tuser[0], m_tdata[15:8], m_tlast,
				m_tuser[1], m_tuser[2]);
	end

	// Hold one byte on the input until it is taken, after an optional gap
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		track.take_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Send a header and its payload; fill < 0 gives random payload bytes
	task automatic send_frame(input logic [7:0] id, input logic [7:0] comp,
			input logic [15:0] total, input int fill);
		int mode;
		mode = (bytes_sent / 280) % 5;
		send_idle_pct = (mode == 1) ? 84 : (mode == 3) ? 6 : 0;
		recv_stall_pct = (mode == 2) ? 84 : (mode == 3) ? 6 : 0;
		send_byte(id);
		send_byte(comp);
		send_byte(total[7:0]);
		send_byte(total[15:8]);
		for (int i = int'(HeaderBytes); i < int'(total); i++)
			send_byte(fill < 0 ? 8'($urandom) : 8'(fill));
		frames_sent++;
	endtask

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		logic [7:0]  id;
		logic [7:0]  comp;
		logic [15:0] total;
		int          sel;

		track = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		bytes_sent = 0;
		frames_sent = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'd0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty payload, short lengths, one and two payload bytes
		send_frame(8'h00, 8'h00, 16'd4, 0);
		send_frame(8'hFF, 8'hFF, 16'd0, 0);
		send_frame(8'h5A, 8'h01, 16'd3, 0);
		send_frame(8'hA5, 8'h00, 16'd5, 8'hFF);
		send_frame(8'h3C, 8'h80, 16'd6, 8'h00);

		// Random frames: mostly short packets, some empty, short or long ones
		while (bytes_sent < 1400) begin
			sel = $urandom_range(99);
			id = 8'($urandom);
			comp = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255, 1));
			if (sel < 10)
				total = 16'(HeaderBytes);
			else if (sel < 20)
				total = 16'($urandom_range(HeaderBytes - 1));
			else if (sel < 24)
				total = {8'd1, 8'($urandom)};
			else
				total = 16'($urandom_range(24, HeaderBytes + 1));
			send_frame(id, comp, total, -1);
		end
		s_tvalid <= 1'b0;

		// Drain the results still due, then let the pipeline settle
		while (track.due_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d frames in %0d bytes: %0d payload bytes, %0d empty, %0d short",
			frames_sent, bytes_sent, track.payload_count, track.empty_count,
			track.short_count);
		$display("input gaps and output stalls varied over five phases; %0d mismatches",
			track.mismatches);
		if (track.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
